### hdl/bfg_pkg.sv
// Shared constants, codes and types of the black frame guard.
package bfg_pkg;

  // Grid geometry and the dark-cell margin of the partial test
  localparam int GRID_COLUMNS = 24;
  localparam int GRID_ROWS    = 14;
  localparam int BLOCK        = 4;
  localparam int DARK_MARGIN  = 5;

  localparam int CELLS = GRID_COLUMNS * GRID_ROWS;
  localparam int AREA  = BLOCK * BLOCK;

  // Cell sum and its division by AREA: reciprocal multiply plus one correction
  localparam int SUM_W       = $clog2(AREA * 255 + 1);
  localparam int RECIP_SHIFT = SUM_W + 1;
  localparam int RECIP       = (2 ** RECIP_SHIFT) / AREA;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int SUBC_W = (BLOCK > 1) ? $clog2(BLOCK) : 1;
  localparam int COL_W  = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int TOTAL_W = $clog2(CELLS * 255 + 1);
  localparam int PCT_W   = $clog2(CELLS * 127 + 1);
  localparam int MARG_W  = $clog2(CELLS + DARK_MARGIN + 1);
  localparam int PCT_SCALE = 100;

  // Summary queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Field widths
  localparam int PIX_W         = 8;
  localparam int LUMA_W        = 8;
  localparam int STAGE_W       = 2;
  localparam int REASON_W      = 2;
  localparam int COUNT_FIELD_W = 9;
  localparam int LUMA_FIELD_W  = 17;
  localparam int REJ_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 9;

  // Stream packing
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 4;
  localparam int TU_START  = 0;
  localparam int TU_STAGE  = 1;
  localparam int TU_DROP   = 3;
  localparam int M_TDATA_W = 72;
  localparam int TD_ALLOW  = 0;
  localparam int TD_REASON = 1;
  localparam int TD_NEWLY  = 3;
  localparam int TD_DARK   = 12;
  localparam int TD_LUMA   = 21;
  localparam int TD_REJ    = 38;
  localparam int TD_USED   = 70;

  localparam logic [STAGE_W-1:0] STAGE_OTHER = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_EXACT = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_MID   = 2'd2;

  localparam logic [REASON_W-1:0] REASON_NONE    = 2'd0;
  localparam logic [REASON_W-1:0] REASON_WHOLE   = 2'd1;
  localparam logic [REASON_W-1:0] REASON_PARTIAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DARK_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIT_LEVEL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_REF_MEAN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLANK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_PCT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REF_DARK_PCT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COLLAPSED = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_DROP     = 3'd7;

  localparam logic [7:0] RST_DARK_LEVEL    = 8'd8;
  localparam logic [7:0] RST_LIT_LEVEL     = 8'd36;
  localparam logic [7:0] RST_MIN_REF_MEAN  = 8'd18;
  localparam logic [7:0] RST_MAX_BLANK     = 8'd4;
  localparam logic [6:0] RST_BLANK_PCT     = 7'd94;
  localparam logic [6:0] RST_REF_DARK_PCT  = 7'd75;
  localparam logic [8:0] RST_MIN_COLLAPSED = 9'd6;
  localparam logic [7:0] RST_MEAN_DROP     = 8'd2;

  typedef struct packed {
    logic [7:0] dark_level;
    logic [7:0] lit_level;
    logic [7:0] min_reference_mean;
    logic [7:0] max_blank_mean;
    logic [6:0] blank_percent;
    logic [6:0] reference_dark_percent;
    logic [8:0] min_collapsed_cells;
    logic [7:0] mean_drop;
  } cfg_t;

  // Per-pixel control carried down the front pipeline
  typedef struct packed {
    logic               valid;
    logic               frame_start;
    logic               drop;
    logic [STAGE_W-1:0] stage;
    logic               cell_done;
    logic               frame_end;
    logic [CELL_W-1:0]  cell_addr;
  } pix_ctl_t;

  // End-of-frame summary handed to the verdict logic
  typedef struct packed {
    logic [TOTAL_W-1:0] frame_total;
    logic [CNT_W-1:0]   frame_dark;
    logic [CNT_W-1:0]   collapsed;
    logic [TOTAL_W-1:0] ref_total;
    logic [CNT_W-1:0]   ref_dark;
  } frame_rec_t;

endpackage

### hdl/bfg_ram.sv
// Generic simple dual-port RAM with registered read.
module bfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bfg_front.sv
// Front end: pixel position, cell sums, cell luma, reference store and frame totals.
module bfg_front import bfg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               pix_valid,
  output logic               pix_ready,
  input  logic [PIX_W-1:0]   red,
  input  logic [PIX_W-1:0]   green,
  input  logic [PIX_W-1:0]   blue,
  input  logic               frame_start,
  input  logic [STAGE_W-1:0] stage,
  input  logic               drop_reference,
  input  logic [QCNT_W-1:0]  q_count,
  output logic               push,
  output frame_rec_t         push_rec
);

  // ---- position state
  logic [SUBC_W-1:0]  sub_x, sub_y;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [CELL_W-1:0]  row_base;
  logic               done;
  logic [STAGE_W-1:0] latched_stage;
  logic [SUM_W-1:0]   column_sums [GRID_COLUMNS];

  logic [SUBC_W-1:0]  sub_x_next, sub_y_next;
  logic [COL_W-1:0]   col_next;
  logic [ROW_W-1:0]   row_next;
  logic [CELL_W-1:0]  row_base_next;
  logic               done_next;

  logic [SUBC_W-1:0]  ex_subx, ex_suby;
  logic [COL_W-1:0]   ex_col;
  logic [ROW_W-1:0]   ex_row;
  logic [CELL_W-1:0]  ex_rb;
  logic [STAGE_W-1:0] stage_new, cur_stage;
  logic               accept, active;
  logic [PIX_W-1:0]   max_rg, max_val;
  logic               x_last, y_last, col_last, row_last, first_in_cell, cell_done;
  logic [SUM_W-1:0]   col_sum_new;

  // ---- pipeline
  pix_ctl_t           p1, p2, p3;
  logic [SUM_W-1:0]   p1_sum, p2_sum;
  logic [LUMA_W-1:0]  p2_q, p3_luma;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   qa, rem;
  logic [LUMA_W-1:0]  luma;
  logic [LUMA_W-1:0]  ref_rdata;
  logic               ref_we;
  logic [QCNT_W:0]    pend;

  // ---- frame accumulators
  logic [TOTAL_W-1:0] frame_total, ref_total, base_total, total_new;
  logic [CNT_W-1:0]   frame_dark, collapsed, ref_dark;
  logic [CNT_W-1:0]   base_dark, base_coll, dark_new, coll_new;
  logic               ref_valid, ref_ok, is_dark, is_coll;

  // Frame ends still in flight reserve a queue slot each
  assign pend = (QCNT_W + 1)'(p1.valid && p1.frame_end)
              + (QCNT_W + 1)'(p2.valid && p2.frame_end)
              + (QCNT_W + 1)'(p3.valid && p3.frame_end);
  assign pix_ready = ((QCNT_W + 1)'(q_count) + pend) < (QCNT_W + 1)'(QDEPTH);
  assign accept = pix_valid && pix_ready;

  always_comb begin
    case (stage)
      STAGE_EXACT: stage_new = STAGE_EXACT;
      STAGE_MID:   stage_new = STAGE_MID;
      default:     stage_new = STAGE_OTHER;
    endcase
  end

  assign ex_subx   = frame_start ? '0 : sub_x;
  assign ex_suby   = frame_start ? '0 : sub_y;
  assign ex_col    = frame_start ? '0 : col;
  assign ex_row    = frame_start ? '0 : row;
  assign ex_rb     = frame_start ? '0 : row_base;
  assign cur_stage = frame_start ? stage_new : latched_stage;
  assign active    = accept && (frame_start || !done);

  assign max_rg  = (green > red) ? green : red;
  assign max_val = (blue > max_rg) ? blue : max_rg;

  assign x_last        = ex_subx == SUBC_W'(BLOCK - 1);
  assign y_last        = ex_suby == SUBC_W'(BLOCK - 1);
  assign col_last      = ex_col == COL_W'(GRID_COLUMNS - 1);
  assign row_last      = ex_row == ROW_W'(GRID_ROWS - 1);
  assign first_in_cell = (ex_subx == '0) && (ex_suby == '0);
  assign cell_done     = x_last && y_last;
  assign col_sum_new   = first_in_cell ? SUM_W'(max_val)
                                       : column_sums[ex_col] + SUM_W'(max_val);

  always_comb begin
    sub_x_next    = ex_subx;
    sub_y_next    = ex_suby;
    col_next      = ex_col;
    row_next      = ex_row;
    row_base_next = ex_rb;
    done_next     = 1'b0;
    if (x_last) begin
      sub_x_next = '0;
      if (col_last) begin
        col_next = '0;
        if (y_last) begin
          sub_y_next = '0;
          if (row_last) begin
            row_next      = '0;
            row_base_next = '0;
            done_next     = 1'b1;
          end else begin
            row_next      = ex_row + 1'b1;
            row_base_next = ex_rb + CELL_W'(GRID_COLUMNS);
          end
        end else begin
          sub_y_next = ex_suby + 1'b1;
        end
      end else begin
        col_next = ex_col + 1'b1;
      end
    end else begin
      sub_x_next = ex_subx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_x         <= '0;
      sub_y         <= '0;
      col           <= '0;
      row           <= '0;
      row_base      <= '0;
      done          <= 1'b0;
      latched_stage <= STAGE_OTHER;
    end else begin
      if (accept && frame_start) begin
        latched_stage <= stage_new;
      end
      if (active) begin
        sub_x    <= sub_x_next;
        sub_y    <= sub_y_next;
        col      <= col_next;
        row      <= row_next;
        row_base <= row_base_next;
        done     <= done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      column_sums[ex_col] <= col_sum_new;
    end
  end

  // ---- stage 1: reciprocal multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      p1.valid <= 1'b0;
    end else begin
      p1.valid <= active;
    end
    p1.frame_start <= frame_start;
    p1.drop        <= drop_reference;
    p1.stage       <= cur_stage;
    p1.cell_done   <= cell_done;
    p1.frame_end   <= cell_done && col_last && row_last;
    p1.cell_addr   <= ex_rb + CELL_W'(ex_col);
    p1_sum         <= col_sum_new;
  end

  assign prod = PROD_W'(p1_sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      p2.valid <= 1'b0;
    end else begin
      p2.valid <= p1.valid;
    end
    p2.frame_start <= p1.frame_start;
    p2.drop        <= p1.drop;
    p2.stage       <= p1.stage;
    p2.cell_done   <= p1.cell_done;
    p2.frame_end   <= p1.frame_end;
    p2.cell_addr   <= p1.cell_addr;
    p2_sum         <= p1_sum;
    p2_q           <= prod[RECIP_SHIFT +: LUMA_W];
  end

  // ---- stage 2: quotient correction, reference write and read
  assign qa   = SUM_W'(p2_q * AREA);
  assign rem  = p2_sum - qa;
  assign luma = (rem >= SUM_W'(AREA)) ? p2_q + 1'b1 : p2_q;

  assign ref_we = p2.valid && p2.cell_done && (p2.stage == STAGE_EXACT);

  bfg_ram #(
    .WIDTH(LUMA_W),
    .DEPTH(CELLS)
  ) u_ref_ram (
    .clk  (clk),
    .we   (ref_we),
    .waddr(p2.cell_addr),
    .wdata(luma),
    .raddr(p2.cell_addr),
    .rdata(ref_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p3.valid <= 1'b0;
    end else begin
      p3.valid <= p2.valid;
    end
    p3.frame_start <= p2.frame_start;
    p3.drop        <= p2.drop;
    p3.stage       <= p2.stage;
    p3.cell_done   <= p2.cell_done;
    p3.frame_end   <= p2.frame_end;
    p3.cell_addr   <= p2.cell_addr;
    p3_luma        <= luma;
  end

  // ---- stage 3: frame totals and reference bookkeeping
  assign base_total = p3.frame_start ? '0 : frame_total;
  assign base_dark  = p3.frame_start ? '0 : frame_dark;
  assign base_coll  = p3.frame_start ? '0 : collapsed;
  assign is_dark    = p3.cell_done && (p3_luma <= cfg.dark_level);
  assign is_coll    = is_dark && (p3.stage == STAGE_MID) && (ref_rdata >= cfg.lit_level);
  assign total_new  = p3.cell_done ? base_total + TOTAL_W'(p3_luma) : base_total;
  assign dark_new   = base_dark + CNT_W'(is_dark);
  assign coll_new   = base_coll + CNT_W'(is_coll);
  assign ref_ok     = ref_valid &&
                      !(p3.frame_start && (p3.drop || (p3.stage == STAGE_EXACT)));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_total <= '0;
      frame_dark  <= '0;
      collapsed   <= '0;
      ref_total   <= '0;
      ref_dark    <= '0;
      ref_valid   <= 1'b0;
    end else if (p3.valid) begin
      frame_total <= total_new;
      frame_dark  <= dark_new;
      collapsed   <= coll_new;
      ref_valid   <= ref_ok;
      if (p3.frame_end && (p3.stage == STAGE_EXACT)) begin
        ref_total <= total_new;
        ref_dark  <= dark_new;
        ref_valid <= 1'b1;
      end
    end
  end

  assign push = p3.valid && p3.frame_end && (p3.stage == STAGE_MID) && ref_ok;
  assign push_rec.frame_total = total_new;
  assign push_rec.frame_dark  = dark_new;
  assign push_rec.collapsed   = coll_new;
  assign push_rec.ref_total   = ref_total;
  assign push_rec.ref_dark    = ref_dark;

endmodule

### hdl/bfg_queue.sv
// Short queue of frame summaries between front and back.
module bfg_queue import bfg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  frame_rec_t        push_rec,
  input  logic              pop,
  output logic              head_valid,
  output frame_rec_t        head_rec,
  output logic [QCNT_W-1:0] count
);

  frame_rec_t        entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  assign head_valid = count != '0;
  assign head_rec   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

### hdl/bfg_back.sv
// Back end: black-frame verdict, reject counter and output register.
module bfg_back import bfg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     q_valid,
  input  frame_rec_t               q_rec,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     allow,
  output logic [REASON_W-1:0]      reject_reason,
  output logic [COUNT_FIELD_W-1:0] newly_dark_cells,
  output logic [COUNT_FIELD_W-1:0] dark_cells,
  output logic [LUMA_FIELD_W-1:0]  luma_total,
  output logic [REJ_W-1:0]         rejected_total
);

  // Mean and percent thresholds scaled by the cell count
  logic [TOTAL_W-1:0] thr_min_ref, thr_blank, thr_drop;
  logic [PCT_W-1:0]   thr_bpct, thr_rpct;
  logic [PCT_W-1:0]   dark_pct, ref_pct;
  logic               whole, partial;
  logic [REASON_W-1:0] reason;

  always_ff @(posedge clk) begin
    thr_min_ref <= TOTAL_W'(cfg.min_reference_mean * CELLS);
    thr_blank   <= TOTAL_W'(cfg.max_blank_mean * CELLS);
    thr_drop    <= TOTAL_W'(cfg.mean_drop * CELLS);
    thr_bpct    <= PCT_W'(cfg.blank_percent * CELLS);
    thr_rpct    <= PCT_W'(cfg.reference_dark_percent * CELLS);
  end

  assign dark_pct = PCT_W'(q_rec.frame_dark * PCT_SCALE);
  assign ref_pct  = PCT_W'(q_rec.ref_dark * PCT_SCALE);

  assign whole = (q_rec.ref_total >= thr_min_ref) &&
                 ((q_rec.frame_total <= thr_blank) ||
                  ((dark_pct >= thr_bpct) && (ref_pct < thr_rpct)));

  assign partial = (CFG_DATA_W'(q_rec.collapsed) >= cfg.min_collapsed_cells) &&
                   (MARG_W'(q_rec.frame_dark) >=
                    MARG_W'(q_rec.ref_dark) + MARG_W'(DARK_MARGIN)) &&
                   (({1'b0, q_rec.frame_total} + {1'b0, thr_drop}) <
                    {1'b0, q_rec.ref_total});

  always_comb begin
    if (whole) begin
      reason = REASON_WHOLE;
    end else if (partial) begin
      reason = REASON_PARTIAL;
    end else begin
      reason = REASON_NONE;
    end
  end

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      rejected_total <= '0;
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
        if (reason != REASON_NONE) begin
          rejected_total <= rejected_total + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      allow            <= reason == REASON_NONE;
      reject_reason    <= reason;
      newly_dark_cells <= COUNT_FIELD_W'(q_rec.collapsed);
      dark_cells       <= COUNT_FIELD_W'(q_rec.frame_dark);
      luma_total       <= LUMA_FIELD_W'(q_rec.frame_total);
    end
  end

endmodule

### hdl/black_frame_guard_top.sv
// Top level of the black frame guard: configuration registers and stream ports.
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  tdata: red, green, blue; tuser: start, stage, drop
//   m_*       out   m_tvalid/m_tready  tdata: allow, reason, counts, totals
//   cfg_*     in    cfg_we             cfg_index, cfg_wdata
//
// One pixel is taken per clock while s_tready is high; the rate is set by the per-pixel cell-sum update.
// m_tvalid rises once the last pixel of a midpoint frame has passed p1, p2, p3, the queue and the output register.
// s_tready drops only when queued and in-flight frame ends fill the four-entry queue.
// Reset is synchronous; the reference store needs no clearing pass.
module black_frame_guard_top import bfg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // red, green, blue
  input  logic [S_TUSER_W-1:0]  s_tuser,   // frame_start, stage[1:0], drop_reference
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // allow, reject_reason[1:0], newly_dark_cells[8:0], dark_cells[8:0],
  // luma_total[16:0], rejected_total[31:0], zero pad
  output logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                     cfg;
  logic                     push, pop, head_valid;
  frame_rec_t               push_rec, head_rec;
  logic [QCNT_W-1:0]        q_count;
  logic                     allow;
  logic [REASON_W-1:0]      reject_reason;
  logic [COUNT_FIELD_W-1:0] newly_dark_cells, dark_cells;
  logic [LUMA_FIELD_W-1:0]  luma_total;
  logic [REJ_W-1:0]         rejected_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dark_level             <= RST_DARK_LEVEL;
      cfg.lit_level              <= RST_LIT_LEVEL;
      cfg.min_reference_mean     <= RST_MIN_REF_MEAN;
      cfg.max_blank_mean         <= RST_MAX_BLANK;
      cfg.blank_percent          <= RST_BLANK_PCT;
      cfg.reference_dark_percent <= RST_REF_DARK_PCT;
      cfg.min_collapsed_cells    <= RST_MIN_COLLAPSED;
      cfg.mean_drop              <= RST_MEAN_DROP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DARK_LEVEL:    cfg.dark_level             <= cfg_wdata[7:0];
        REG_LIT_LEVEL:     cfg.lit_level              <= cfg_wdata[7:0];
        REG_MIN_REF_MEAN:  cfg.min_reference_mean     <= cfg_wdata[7:0];
        REG_MAX_BLANK:     cfg.max_blank_mean         <= cfg_wdata[7:0];
        REG_BLANK_PCT:     cfg.blank_percent          <= cfg_wdata[6:0];
        REG_REF_DARK_PCT:  cfg.reference_dark_percent <= cfg_wdata[6:0];
        REG_MIN_COLLAPSED: cfg.min_collapsed_cells    <= cfg_wdata[8:0];
        REG_MEAN_DROP:     cfg.mean_drop              <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  bfg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .pix_valid     (s_tvalid),
    .pix_ready     (s_tready),
    .red           (s_tdata[0 +: PIX_W]),
    .green         (s_tdata[PIX_W +: PIX_W]),
    .blue          (s_tdata[2*PIX_W +: PIX_W]),
    .frame_start   (s_tuser[TU_START]),
    .stage         (s_tuser[TU_STAGE +: STAGE_W]),
    .drop_reference(s_tuser[TU_DROP]),
    .q_count       (q_count),
    .push          (push),
    .push_rec      (push_rec)
  );

  bfg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .head_valid(head_valid),
    .head_rec  (head_rec),
    .count     (q_count)
  );

  bfg_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (head_valid),
    .q_rec           (head_rec),
    .q_pop           (pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .allow           (allow),
    .reject_reason   (reject_reason),
    .newly_dark_cells(newly_dark_cells),
    .dark_cells      (dark_cells),
    .luma_total      (luma_total),
    .rejected_total  (rejected_total)
  );

  assign m_tdata[TD_ALLOW]                   = allow;
  assign m_tdata[TD_REASON +: REASON_W]      = reject_reason;
  assign m_tdata[TD_NEWLY +: COUNT_FIELD_W]  = newly_dark_cells;
  assign m_tdata[TD_DARK +: COUNT_FIELD_W]   = dark_cells;
  assign m_tdata[TD_LUMA +: LUMA_FIELD_W]    = luma_total;
  assign m_tdata[TD_REJ +: REJ_W]            = rejected_total;
  assign m_tdata[M_TDATA_W-1:TD_USED]        = '0;

endmodule

### hdl/bfg_checker.sv
// Port-level checks of the black frame guard, bound to the top level.
module bfg_checker import bfg_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_TDATA_W-1:0]  m_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // allow is set exactly when no reject reason is given
  a_allow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TD_ALLOW] == (m_tdata[TD_REASON +: REASON_W] == REASON_NONE))
    else $error("allow disagrees with reject reason");

  // collapsed cells are a subset of the dark cells
  a_collapsed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TD_NEWLY +: COUNT_FIELD_W] <= m_tdata[TD_DARK +: COUNT_FIELD_W])
    else $error("more collapsed cells than dark cells");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind black_frame_guard_top bfg_checker u_bfg_checker (.*);

### verif/black_frame_guard_top_tb.sv
// Self-checking testbench for black_frame_guard_top: shaped frames in, verdicts predicted and compared.
module black_frame_guard_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfg_pkg::*;

  localparam logic [STAGE_W-1:0] STAGE_UNUSED = 2'd3;
  localparam int FRAME_W      = GRID_COLUMNS * BLOCK;
  localparam int FRAME_H      = GRID_ROWS * BLOCK;
  localparam int FRAME_PIXELS = FRAME_W * FRAME_H;
  localparam int IDLE_PCT     = 36;
  localparam int HOLD_CYCLES  = 40000;
  localparam int LATENCY_PAD  = 16;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int PHASE_VERDICTS = 5;

  typedef enum {SCENE_RANDOM, SCENE_BRIGHT, SCENE_BLACK, SCENE_COLLAPSE, SCENE_ALIKE,
                SCENE_DIM} scene_t;

  typedef struct {
    bit                     allow;
    bit [REASON_W-1:0]      reason;
    bit [COUNT_FIELD_W-1:0] newly_dark;
    bit [COUNT_FIELD_W-1:0] dark;
    bit [LUMA_FIELD_W-1:0]  luma_total;
    bit [REJ_W-1:0]         rejected;
  } verdict_t;

  class guard_scoreboard;
    cfg_t               cfg;
    bit [SUM_W-1:0]     col_sum [GRID_COLUMNS];
    bit [LUMA_W-1:0]    ref_luma [CELLS];
    bit                 ref_ok;
    bit [TOTAL_W-1:0]   ref_total;
    bit [CNT_W-1:0]     ref_dark;
    bit [TOTAL_W-1:0]   frame_total;
    bit [CNT_W-1:0]     frame_dark;
    bit [CNT_W-1:0]     collapsed;
    int                 px;
    int                 py;
    bit [STAGE_W-1:0]   stage;
    bit [REJ_W-1:0]     rejects;
    verdict_t           pending_verdicts [$];
    int                 issued;
    int                 seen;
    int                 errors;

    function new();
      cfg = '{RST_DARK_LEVEL, RST_LIT_LEVEL, RST_MIN_REF_MEAN, RST_MAX_BLANK, RST_BLANK_PCT,
              RST_REF_DARK_PCT, RST_MIN_COLLAPSED, RST_MEAN_DROP};
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] v);
      case (idx)
        REG_DARK_LEVEL:    cfg.dark_level = v[7:0];
        REG_LIT_LEVEL:     cfg.lit_level = v[7:0];
        REG_MIN_REF_MEAN:  cfg.min_reference_mean = v[7:0];
        REG_MAX_BLANK:     cfg.max_blank_mean = v[7:0];
        REG_BLANK_PCT:     cfg.blank_percent = v[6:0];
        REG_REF_DARK_PCT:  cfg.reference_dark_percent = v[6:0];
        REG_MIN_COLLAPSED: cfg.min_collapsed_cells = v[8:0];
        REG_MEAN_DROP:     cfg.mean_drop = v[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    // Notes one accepted pixel transfer; queues a verdict at the end of a judged frame
    function void note_pixel(bit [S_TDATA_W-1:0] data, bit [S_TUSER_W-1:0] user);
      bit [7:0] m;
      int col, cell_idx;
      bit [LUMA_W-1:0] luma;
      longint unsigned ft, rt, fd, rd, n;
      bit whole, partial;
      bit [REASON_W-1:0] reason;
      verdict_t v;
      if (user[TU_START]) begin
        px = 0;
        py = 0;
        stage = user[TU_STAGE +: STAGE_W];
        if (stage == STAGE_UNUSED) stage = STAGE_OTHER;
        frame_total = 0;
        frame_dark = 0;
        collapsed = 0;
        if (user[TU_DROP] || stage == STAGE_EXACT) ref_ok = 0;
      end
      if (py >= FRAME_H || px >= FRAME_W) return;
      m = data[7:0];
      if (data[15:8] > m) m = data[15:8];
      if (data[23:16] > m) m = data[23:16];
      col = px / BLOCK;
      if (px % BLOCK == 0 && py % BLOCK == 0) col_sum[col] = SUM_W'(m);
      else col_sum[col] += SUM_W'(m);
      if (px % BLOCK == BLOCK - 1 && py % BLOCK == BLOCK - 1) begin
        cell_idx = (py / BLOCK) * GRID_COLUMNS + col;
        luma = LUMA_W'(col_sum[col] / AREA);
        frame_total += TOTAL_W'(luma);
        if (luma <= cfg.dark_level) begin
          frame_dark++;
          if (stage == STAGE_MID && ref_luma[cell_idx] >= cfg.lit_level) collapsed++;
        end
        if (stage == STAGE_EXACT) ref_luma[cell_idx] = luma;
      end
      px++;
      if (px < FRAME_W) return;
      px = 0;
      py++;
      if (py < FRAME_H) return;
      if (stage == STAGE_EXACT) begin
        ref_total = frame_total;
        ref_dark = frame_dark;
        ref_ok = 1;
        return;
      end
      if (stage != STAGE_MID || !ref_ok) return;
      // mean tests are done on totals scaled by the cell count
      ft = frame_total;
      rt = ref_total;
      fd = frame_dark;
      rd = ref_dark;
      n = CELLS;
      whole = rt >= cfg.min_reference_mean * n &&
              (ft <= cfg.max_blank_mean * n ||
               (fd * PCT_SCALE >= n * cfg.blank_percent &&
                rd * PCT_SCALE < n * cfg.reference_dark_percent));
      partial = collapsed >= cfg.min_collapsed_cells && fd >= rd + DARK_MARGIN &&
                ft + cfg.mean_drop * n < rt;
      reason = whole ? REASON_WHOLE : (partial ? REASON_PARTIAL : REASON_NONE);
      if (reason != REASON_NONE) rejects++;
      v.allow = (reason == REASON_NONE);
      v.reason = reason;
      v.newly_dark = collapsed;
      v.dark = frame_dark;
      v.luma_total = frame_total;
      v.rejected = rejects;
      pending_verdicts.push_back(v);
      issued++;
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task match_field(string name, logic [31:0] got, bit [31:0] want);
      if (got !== want)
        report($sformatf("verdict %0d %s: got %0h, want %0h", seen, name, got, want));
    endtask

    task check_verdict(logic [M_TDATA_W-1:0] d);
      verdict_t w;
      seen++;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("verdict %0d arrived with none outstanding", seen));
        return;
      end
      w = pending_verdicts.pop_front();
      match_field("allow", d[TD_ALLOW], w.allow);
      match_field("reject_reason", d[TD_REASON +: REASON_W], w.reason);
      match_field("newly_dark_cells", d[TD_NEWLY +: COUNT_FIELD_W], w.newly_dark);
      match_field("dark_cells", d[TD_DARK +: COUNT_FIELD_W], w.dark);
      match_field("luma_total", d[TD_LUMA +: LUMA_FIELD_W], w.luma_total);
      match_field("rejected_total", d[TD_REJ +: REJ_W], w.rejected);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // red, green, blue
  logic [S_TUSER_W-1:0]  s_tuser = '0;   // frame_start, stage[1:0], drop_reference
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // allow, reject_reason, newly_dark_cells, dark_cells, luma_total, rejected_total, pad
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  guard_scoreboard sb = new();
  int  level [CELLS];
  int  ref_level [CELLS];
  bit  steady;
  bit  hold_ask;
  int  hold_left;
  int unsigned cycles;

  black_frame_guard_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Verdict receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic bit [S_TUSER_W-1:0] pack_user(bit start, logic [STAGE_W-1:0] stg,
                                                   bit drop);
    bit [S_TUSER_W-1:0] u;
    u = '0;
    u[TU_START] = start;
    u[TU_STAGE +: STAGE_W] = stg;
    u[TU_DROP] = drop;
    return u;
  endfunction

  // A pixel whose max channel averages to at or just under lvl over a cell
  function automatic bit [S_TDATA_W-1:0] pixel_for(int lvl);
    bit [7:0] m;
    bit [7:0] ch [3];
    m = 8'($urandom_range(lvl >= 3 ? lvl - 3 : 0, lvl));
    for (int k = 0; k < 3; k++) ch[k] = 8'($urandom_range(0, m));
    ch[$urandom_range(2)] = m;
    return {ch[2], ch[1], ch[0]};
  endfunction

  function automatic void fill_scene(scene_t s);
    int dk, lt, pct, j, t, r;
    dk = sb.cfg.dark_level;
    lt = sb.cfg.lit_level;
    pct = $urandom_range(5, 40);
    for (int c = 0; c < CELLS; c++) begin
      case (s)
        SCENE_BRIGHT:
          level[c] = ($urandom_range(99) < 85) ? $urandom_range(lt + 3 > 255 ? 255 : lt + 3, 255)
                                               : $urandom_range(0, dk);
        SCENE_BLACK:    level[c] = $urandom_range(0, dk < 10 ? dk : 10);
        SCENE_COLLAPSE: level[c] = ($urandom_range(99) < pct) ? $urandom_range(0, dk)
                                                              : ref_level[c];
        SCENE_ALIKE: begin
          j = $urandom_range(0, 6);
          t = ref_level[c] + j - 3;
          level[c] = t < 0 ? 0 : (t > 255 ? 255 : t);
        end
        SCENE_DIM:      level[c] = $urandom_range(0, 40);
        default: begin
          r = $urandom_range(9);
          level[c] = (r == 0) ? 0 : ((r == 1) ? 255 : $urandom_range(0, 255));
        end
      endcase
    end
  endfunction

  task automatic send_pixel(bit [S_TDATA_W-1:0] data, bit [S_TUSER_W-1:0] user);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tuser <= user;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(data, user);
  endtask

  // Raster scan of the current scene; after the first pixel the start bit is clear and other tuser bits are noise
  task automatic send_frame(logic [STAGE_W-1:0] stg, bit drop, int length);
    bit [S_TUSER_W-1:0] user;
    int x, y;
    for (int n = 0; n < length; n++) begin
      x = n % FRAME_W;
      y = n / FRAME_W;
      user = S_TUSER_W'($urandom_range(2 ** S_TUSER_W - 1));
      user[TU_START] = 1'b0;
      if (n == 0) user = pack_user(1'b1, stg, drop);
      send_pixel(pixel_for(level[(y / BLOCK) * GRID_COLUMNS + x / BLOCK]), user);
    end
  endtask

  task automatic send_stray(int count);
    bit [S_TUSER_W-1:0] user;
    repeat (count) begin
      user = S_TUSER_W'($urandom_range(2 ** S_TUSER_W - 1));
      user[TU_START] = 1'b0;
      send_pixel(S_TDATA_W'($urandom), user);
    end
  endtask

  task automatic run_sequence();
    int pick, r;
    scene_t sc;
    pick = $urandom_range(99);
    if (pick < 10) begin
      fill_scene(SCENE_RANDOM);
      send_frame(STAGE_W'($urandom_range(3)), 1'($urandom_range(1)),
                 $urandom_range(1, 400));
      send_stray($urandom_range(0, 5));
      return;
    end
    fill_scene(pick < 55 ? SCENE_BRIGHT : (pick < 80 ? SCENE_RANDOM : SCENE_DIM));
    if ($urandom_range(99) < 8) begin
      // exact frame cut short: leaves no usable reference
      send_frame(STAGE_EXACT, 1'($urandom_range(1)), $urandom_range(1, FRAME_PIXELS - 1));
      return;
    end
    send_frame(STAGE_EXACT, $urandom_range(99) < 10, FRAME_PIXELS);
    ref_level = level;
    if ($urandom_range(99) < 8) begin
      fill_scene(SCENE_RANDOM);
      send_frame($urandom_range(1) ? STAGE_OTHER : STAGE_UNUSED, 1'b0, FRAME_PIXELS);
    end
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(99);
      sc = r < 25 ? SCENE_BLACK : (r < 55 ? SCENE_COLLAPSE : (r < 80 ? SCENE_ALIKE :
           (r < 90 ? SCENE_DIM : SCENE_RANDOM)));
      fill_scene(sc);
      send_frame(STAGE_MID, $urandom_range(99) < 6, FRAME_PIXELS);
      if ($urandom_range(99) < 10) send_stray($urandom_range(1, 8));
    end
  endtask

  task automatic play_phase(int want);
    int start;
    start = sb.issued;
    while (sb.issued - start < want) run_sequence();
  endtask

  // Sender pauses until every outstanding verdict is back, then lets the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic put_register(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    sb.set_register(idx, CFG_DATA_W'(val));
  endtask

  task automatic apply_settings(int dark, int lit, int ref_mean, int blank_mean, int blank_pct,
                                int ref_pct, int min_coll, int drop);
    put_register(REG_DARK_LEVEL, dark);
    put_register(REG_LIT_LEVEL, lit);
    put_register(REG_MIN_REF_MEAN, ref_mean);
    put_register(REG_MAX_BLANK, blank_mean);
    put_register(REG_BLANK_PCT, blank_pct);
    put_register(REG_REF_DARK_PCT, ref_pct);
    put_register(REG_MIN_COLLAPSED, min_coll);
    put_register(REG_MEAN_DROP, drop);
    cfg_we <= 1'b0;
  endtask

  task automatic directed();
    // pixels ahead of any frame start, drop without start
    send_pixel(24'h000000, pack_user(1'b0, STAGE_UNUSED, 1'b1));
    send_pixel(24'hFFFFFF, pack_user(1'b0, STAGE_MID, 1'b0));
    send_pixel(24'h0000FF, pack_user(1'b0, STAGE_EXACT, 1'b1));
    // stage code three with drop
    send_pixel(24'h00FF00, pack_user(1'b1, STAGE_UNUSED, 1'b1));
    send_pixel(24'hFF0000, pack_user(1'b0, STAGE_OTHER, 1'b0));
    send_pixel(24'hFFFFFF, pack_user(1'b0, STAGE_UNUSED, 1'b1));
    // midpoint frame with no reference, cut short
    send_pixel(24'hFF00FF, pack_user(1'b1, STAGE_MID, 1'b0));
    send_pixel(24'h00FFFF, pack_user(1'b0, STAGE_MID, 1'b1));
    send_pixel(24'h808080, pack_user(1'b0, STAGE_OTHER, 1'b0));
    send_pixel(24'h7F7F7F, pack_user(1'b0, STAGE_EXACT, 1'b0));
    // exact frame cut short
    send_pixel(24'hFFFFFF, pack_user(1'b1, STAGE_EXACT, 1'b0));
    send_pixel(24'hFFFFFF, pack_user(1'b0, STAGE_UNUSED, 1'b0));
    send_pixel(24'h000000, pack_user(1'b0, STAGE_MID, 1'b1));
    send_pixel(24'h010203, pack_user(1'b0, STAGE_OTHER, 1'b0));
    send_pixel(24'hFEFDFC, pack_user(1'b0, STAGE_OTHER, 1'b0));
    // other frame, exact frame restarted with drop
    send_pixel(24'h123456, pack_user(1'b1, STAGE_OTHER, 1'b0));
    send_pixel(24'hABCDEF, pack_user(1'b0, STAGE_OTHER, 1'b1));
    send_pixel(24'h0F0F0F, pack_user(1'b1, STAGE_EXACT, 1'b1));
    send_pixel(24'hF0F0F0, pack_user(1'b0, STAGE_UNUSED, 1'b0));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    directed();
    play_phase(PHASE_VERDICTS);

    settle();
    apply_settings($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 100), $urandom_range(0, 100),
                   $urandom_range(0, CELLS), $urandom_range(0, 255));
    play_phase(PHASE_VERDICTS);

    settle();
    apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
    play_phase(PHASE_VERDICTS);

    settle();
    apply_settings(255, 255, 255, 255, 100, 100, CELLS, 255);
    steady = 1;
    play_phase(PHASE_VERDICTS);
    steady = 0;

    settle();
    apply_settings($urandom_range(0, 40), $urandom_range(20, 200), $urandom_range(0, 60),
                   $urandom_range(0, 30), $urandom_range(50, 100), $urandom_range(30, 100),
                   $urandom_range(0, 40), $urandom_range(0, 20));
    play_phase(PHASE_VERDICTS);

    // receiver holds off while frame ends pile up and the input stalls
    settle();
    apply_settings(RST_DARK_LEVEL, RST_LIT_LEVEL, RST_MIN_REF_MEAN, RST_MAX_BLANK,
                   RST_BLANK_PCT, RST_REF_DARK_PCT, RST_MIN_COLLAPSED, RST_MEAN_DROP);
    steady = 1;
    hold_ask = 1;
    fill_scene(SCENE_BRIGHT);
    send_frame(STAGE_EXACT, 1'b0, FRAME_PIXELS);
    ref_level = level;
    repeat (6) begin
      fill_scene($urandom_range(1) ? SCENE_COLLAPSE : SCENE_BLACK);
      send_frame(STAGE_MID, 1'b0, FRAME_PIXELS);
    end
    steady = 0;

    settle();
    apply_settings($urandom_range(0, 40), $urandom_range(20, 200), $urandom_range(0, 60),
                   $urandom_range(0, 30), $urandom_range(50, 100), $urandom_range(30, 100),
                   $urandom_range(0, 40), $urandom_range(0, 20));
    play_phase(PHASE_VERDICTS);

    settle();
    if (sb.pending() != 0) sb.report($sformatf("%0d verdicts never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
